// File: design/bhe_pkg.sv
// Package for the byte histogram engine: sizes, operation codes and the
// word that the bin update stage hands to the response queue.
// No dependencies.
`default_nettype none

package bhe_pkg;

   // Counter and bin geometry.
   localparam int COUNT_BITS = 24;
   localparam int NUM_BINS   = 256;
   localparam int BIN_BITS   = $clog2(NUM_BINS);
   localparam int OP_BITS    = 2;
   localparam int BYTE_BITS  = 8;
   localparam int OUT_BITS   = 24;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [OUT_BITS-1:0]   OUT_MAX   = {OUT_BITS{1'b1}};

   // Operation codes of a request word. Code 3 is unused and ignored.
   typedef enum logic [OP_BITS-1:0] {
      OP_COUNT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // One response word pushed from the update stage into the queue.
   typedef struct packed {
      logic                 valid;
      logic [OUT_BITS-1:0]  count;
      logic [BYTE_BITS-1:0] echo;
   } rsp_push_type;

   // Clamp a bin counter to the width of the response field.
   function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] value);
      logic [32:0] wide;
      wide = 33'(value);
      if (wide > 33'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return wide[OUT_BITS-1:0];
   endfunction

endpackage : bhe_pkg

`default_nettype wire

// File: design/bhe_req_if.sv
// Request and response channel interfaces of the byte histogram engine.
// Depends on bhe_pkg for the field widths.
`default_nettype none

interface bhe_req_if;
   logic                           valid;
   logic                           ready;
   logic [bhe_pkg::OP_BITS-1:0]    operation;
   logic [bhe_pkg::BYTE_BITS-1:0]  sample;
   logic [bhe_pkg::BYTE_BITS-1:0]  bin_select;

   modport source (output valid, output operation, output sample, output bin_select,
                   input ready);
   modport sink   (input valid, input operation, input sample, input bin_select,
                   output ready);
endinterface : bhe_req_if

interface bhe_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bhe_pkg::OUT_BITS-1:0]   bin_count;
   logic [bhe_pkg::BYTE_BITS-1:0]  bin_echo;

   modport source (output valid, output bin_count, output bin_echo, input ready);
   modport sink   (input valid, input bin_count, input bin_echo, output ready);
endinterface : bhe_rsp_if

`default_nettype wire

// File: design/bhe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module bhe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : bhe_ram

`default_nettype wire

// File: design/bhe_bin_update.sv
// Read-modify-write pipeline over the bin counter RAM, with per-bin valid
// flags for clearing and a bypass for back-to-back hits on one bin.
// Depends on bhe_pkg and bhe_ram.
`default_nettype none

module bhe_bin_update (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [bhe_pkg::OP_BITS-1:0]   operation,
   input  wire logic [bhe_pkg::BYTE_BITS-1:0] sample,
   input  wire logic [bhe_pkg::BYTE_BITS-1:0] bin_select,
   output bhe_pkg::rsp_push_type              push
);
   import bhe_pkg::*;

   op_type                 op0;
   logic [BIN_BITS-1:0]    addr0;

   logic                   s1_valid_ff, s1_valid_in;
   op_type                 s1_op_ff, s1_op_in;
   logic [BIN_BITS-1:0]    s1_addr_ff, s1_addr_in;
   logic                   byp_hit_ff, byp_hit_in;
   logic [COUNT_BITS-1:0]  byp_data_ff, byp_data_in;
   logic [NUM_BINS-1:0]    bin_valid_ff, bin_valid_in;

   logic [COUNT_BITS-1:0]  ram_rd_data;
   logic [COUNT_BITS-1:0]  old_count;
   logic [COUNT_BITS-1:0]  new_count;
   logic                   wr_en;
   logic                   clear_en;

   // Decode the incoming word and pick the bin it addresses.
   always_comb begin
      op0 = op_type'(operation);
      unique case (op0)
         OP_READ:  addr0 = bin_select[BIN_BITS-1:0];
         default:  addr0 = sample[BIN_BITS-1:0];
      endcase
   end

   bhe_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_bhe_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_count),
      .rd_en   (accept),
      .rd_addr (addr0),
      .rd_data (ram_rd_data)
   );

   // Second stage: resolve the current count of the bin and update it.
   // A bin written in the previous cycle comes from the bypass register,
   // a bin not written since the last clear reads as zero.
   always_comb begin
      wr_en    = s1_valid_ff && (s1_op_ff == OP_COUNT);
      clear_en = s1_valid_ff && (s1_op_ff == OP_CLEAR);

      if (byp_hit_ff) begin
         old_count = byp_data_ff;
      end else if (bin_valid_ff[s1_addr_ff]) begin
         old_count = ram_rd_data;
      end else begin
         old_count = '0;
      end

      if (old_count == COUNT_MAX) begin
         new_count = old_count;
      end else begin
         new_count = old_count + COUNT_BITS'(1);
      end

      push.valid = s1_valid_ff && (s1_op_ff == OP_READ);
      push.count = sat_out(old_count);
      push.echo  = BYTE_BITS'(s1_addr_ff);
   end

   // Next state of the pipeline, the bypass and the valid flags.
   always_comb begin
      s1_valid_in = accept;
      s1_op_in    = op0;
      s1_addr_in  = addr0;
      byp_hit_in  = wr_en && (s1_addr_ff == addr0);
      byp_data_in = new_count;

      bin_valid_in = bin_valid_ff;
      if (clear_en) begin
         bin_valid_in = '0;
      end else if (wr_en) begin
         bin_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_hit_ff   <= 1'b0;
         bin_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         byp_hit_ff   <= byp_hit_in;
         bin_valid_ff <= bin_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_addr_ff  <= s1_addr_in;
      byp_data_ff <= byp_data_in;
   end

endmodule : bhe_bin_update

`default_nettype wire

// File: design/bhe_rsp_queue.sv
// Two-word response queue between the update stage and the response channel.
// It also tells the request side whether a new word may enter.
// Depends on bhe_pkg.
`default_nettype none

module bhe_rsp_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bhe_pkg::rsp_push_type         push,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [bhe_pkg::OUT_BITS-1:0]       rsp_count,
   output logic [bhe_pkg::BYTE_BITS-1:0]      rsp_echo,
   output logic                               space_ok
);
   import bhe_pkg::*;

   logic [1:0]    level_ff, level_in;
   rsp_push_type  head_ff, head_in;
   rsp_push_type  tail_ff, tail_in;
   logic          pop;

   assign rsp_valid = (level_ff != 2'd0);
   assign rsp_count = head_ff.count;
   assign rsp_echo  = head_ff.echo;
   assign pop       = rsp_valid && rsp_ready;

   // A new request may enter when the queue can take every response that
   // is already in flight plus one more.
   assign space_ok = (level_ff == 2'd0) || ((level_ff == 2'd1) && !push.valid);

   // Queue update.
   always_comb begin
      level_in = level_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push.valid, pop})
         2'b11: begin
            if (level_ff == 2'd1) begin
               head_in = push;
            end else begin
               head_in = tail_ff;
               tail_in = push;
            end
         end
         2'b01: begin
            head_in  = tail_ff;
            level_in = level_ff - 2'd1;
         end
         2'b10: begin
            if (level_ff == 2'd0) begin
               head_in = push;
            end else begin
               tail_in = push;
            end
            level_in = level_ff + 2'd1;
         end
         default: begin
            level_in = level_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule : bhe_rsp_queue

`default_nettype wire

// File: design/byte_histogram_engine_top.sv
// A read's word goes from the stage-one registers to the response queue head register
// if the queue is empty. Throughput: one count or clear word per cycle; a request
// waits while two response words are queued, or while one is queued and a read leaves
// the update stage, so back-to-back reads to a ready receiver run two words in three.
// Clear works through the per-bin valid flags; reset clears them at once,
// so bins read zero right after reset with no sweep over the RAM.
// Depends on bhe_pkg, the channel interfaces, bhe_bin_update and bhe_rsp_queue.
`default_nettype none

module byte_histogram_engine_top (
   input  wire logic  clock,
   input  wire logic  reset,
   bhe_req_if.sink    req_chan,
   bhe_rsp_if.source  rsp_chan
);
   import bhe_pkg::*;

   rsp_push_type  push;
   logic          space_ok;
   logic          accept;

   // Request handshake.
   assign req_chan.ready = !reset && space_ok;
   assign accept         = req_chan.valid && req_chan.ready;

   bhe_bin_update u_bhe_bin_update (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_chan.operation),
      .sample     (req_chan.sample),
      .bin_select (req_chan.bin_select),
      .push       (push)
   );

   bhe_rsp_queue u_bhe_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_count (rsp_chan.bin_count),
      .rsp_echo  (rsp_chan.bin_echo),
      .space_ok  (space_ok)
   );

endmodule : byte_histogram_engine_top

`default_nettype wire

// File: design/bhe_checker.sv
// Port-level checks for the byte histogram engine, bound to the top level.
// Depends on bhe_pkg and byte_histogram_engine_top.
`default_nettype none

module bhe_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [bhe_pkg::OP_BITS-1:0]   req_operation,
   input  wire logic [bhe_pkg::BYTE_BITS-1:0] req_bin_select,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [bhe_pkg::OUT_BITS-1:0]  rsp_bin_count,
   input  wire logic [bhe_pkg::BYTE_BITS-1:0] rsp_bin_echo
);
   import bhe_pkg::*;

   logic read_acc;
   logic clear_acc;

   assign read_acc  = req_valid && req_ready && (req_operation == OP_READ);
   assign clear_acc = req_valid && req_ready && (req_operation == OP_CLEAR);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count)
                                  && $stable(rsp_bin_echo))
      else $error("response word changed while stalled");

   // A response into an empty queue comes from an earlier accepted read and echoes its bin select.
   a_first_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(read_acc, 2) && (rsp_bin_echo == $past(req_bin_select, 2)))
      else $error("response without a matching read");

   // A read right after a clear sees an empty bin.
   a_clear_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(clear_acc, 3) |-> (rsp_bin_count == '0))
      else $error("bin not cleared");

   // With no word waiting, the engine always takes a request.
   a_ready_empty: assert property (@(posedge clock)
      !reset && !rsp_valid |-> req_ready)
      else $error("request stalled with empty queue");

   // Reset empties the response side.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule : bhe_checker

bind byte_histogram_engine_top bhe_checker u_bhe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_operation  (req_chan.operation),
   .req_bin_select (req_chan.bin_select),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_bin_count  (rsp_chan.bin_count),
   .rsp_bin_echo   (rsp_chan.bin_echo)
);

`default_nettype wire
